### design/tfs_pkg.sv
`timescale 1ns / 1ps

package tfs_pkg;

    localparam int FRAME_LEN = 8;
    localparam int IDX_W     = $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

    localparam logic [7:0] TYPE_DATA  = 8'h10;
    localparam logic [7:0] TYPE_EMPTY = 8'h00;
    localparam logic [7:0] CHECK_BASE = 8'hFF;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_START_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_MASK = 2'd2;

    localparam logic [7:0] RST_START_CODE  = 8'd126;
    localparam logic [7:0] RST_ESCAPE_CODE = 8'd125;
    localparam logic [7:0] RST_ESCAPE_MASK = 8'd32;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [15:0] sensor_id;
        logic [31:0] data_value;
        logic        empty_frame;
    } in_item_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       frame_end;
    } out_item_t;

    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] escape_code;
        logic [7:0] escape_mask;
    } cfg_t;

    // one frame ready to go on the line: bytes already masked where escaped
    typedef struct packed {
        logic [FRAME_LEN-1:0][7:0] bytes;
        logic [FRAME_LEN-1:0]      esc;
    } frame_t;

endpackage

### design/tfs_front.sv
`timescale 1ns / 1ps

module tfs_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  tfs_pkg::cfg_t     cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  tfs_pkg::in_item_t s_data,
    output logic              q_valid,
    input  logic              q_ready,
    output tfs_pkg::frame_t   q_data
);
    import tfs_pkg::*;

    in_item_t raw_reg;
    logic     raw_valid_reg;
    logic     raw_valid_next;

    logic [FRAME_LEN-1:0][7:0] plain;
    logic [31:0]               val;
    logic [10:0]               total;
    logic [8:0]                fold1;
    logic [7:0]                fold2;

    assign s_ready = !raw_valid_reg || q_ready;
    assign q_valid = raw_valid_reg;

    always_comb begin
        raw_valid_next = raw_valid_reg;
        if (q_ready) begin
            raw_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            raw_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_valid_reg <= 1'b0;
        end else begin
            raw_valid_reg <= raw_valid_next;
        end
        if (s_valid && s_ready) begin
            raw_reg <= s_data;
        end
    end

    always_comb begin
        val      = raw_reg.empty_frame ? 32'd0 : raw_reg.data_value;
        plain[0] = raw_reg.empty_frame ? TYPE_EMPTY : TYPE_DATA;
        plain[1] = raw_reg.sensor_id[7:0];
        plain[2] = raw_reg.sensor_id[15:8];
        plain[3] = val[7:0];
        plain[4] = val[15:8];
        plain[5] = val[23:16];
        plain[6] = val[31:24];
        // end-around carry sum: fold the carries back twice
        total = 11'(plain[0]) + 11'(plain[1]) + 11'(plain[2]) + 11'(plain[3])
              + 11'(plain[4]) + 11'(plain[5]) + 11'(plain[6]);
        fold1 = 9'(total[7:0]) + 9'(total[10:8]);
        fold2 = fold1[7:0] + 8'(fold1[8]);
        plain[FRAME_LEN-1] = CHECK_BASE - fold2;
    end

    always_comb begin
        for (int i = 0; i < FRAME_LEN; i++) begin
            q_data.esc[i]   = (plain[i] == cfg.start_code) || (plain[i] == cfg.escape_code);
            q_data.bytes[i] = q_data.esc[i] ? (plain[i] & ~cfg.escape_mask) : plain[i];
        end
    end

endmodule

### design/tfs_queue.sv
`timescale 1ns / 1ps

module tfs_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  tfs_pkg::frame_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output tfs_pkg::frame_t pop_data
);
    import tfs_pkg::*;

    frame_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/tfs_back.sv
`timescale 1ns / 1ps

module tfs_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  tfs_pkg::cfg_t      cfg,
    input  logic               q_valid,
    output logic               q_ready,
    input  tfs_pkg::frame_t    q_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tfs_pkg::out_item_t m_data
);
    import tfs_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             pre_reg;   // escape prefix already sent for this byte
    logic             pre_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    out_item_t        m_data_reg;
    out_item_t        m_data_next;

    logic load;
    logic adv;
    logic send_prefix;

    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;
    assign load        = !m_valid_reg || m_ready;
    assign adv         = load && q_valid;
    assign send_prefix = q_data.esc[idx_reg] && !pre_reg;
    assign q_ready     = adv && !send_prefix && (idx_reg == LAST_IDX);

    always_comb begin
        idx_next     = idx_reg;
        pre_next     = pre_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next = q_valid;
        end
        if (adv) begin
            if (send_prefix) begin
                m_data_next.line_byte = cfg.escape_code;
                m_data_next.frame_end = 1'b0;
                pre_next              = 1'b1;
            end else begin
                m_data_next.line_byte = q_data.bytes[idx_reg];
                m_data_next.frame_end = (idx_reg == LAST_IDX);
                pre_next              = 1'b0;
                idx_next              = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            pre_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            pre_reg     <= pre_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

endmodule

### design/telemetry_frame_serializer_core.sv
`timescale 1ns / 1ps
// A report goes through the front register, a queue slot and the output byte register.
// Throughput: one line byte per cycle while m_ready holds, set by the serializer's single
// output byte register; a report is 8 to 16 line bytes (8 plus one per escaped byte).
// Reports are accepted back to back while a 2-frame queue has room.
// Reset (aresetn low, synchronous): queue and serializer empty, codes back to 126/125/32.
module telemetry_frame_serializer_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                        cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tfs_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tfs_pkg::out_item_t                m_data
);
    import tfs_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   fq_valid;
    logic   fq_ready;
    frame_t fq_data;
    logic   qb_valid;
    logic   qb_ready;
    frame_t qb_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_START_CODE:  cfg_next.start_code  = cfg_data;
                REG_ESCAPE_CODE: cfg_next.escape_code = cfg_data;
                REG_ESCAPE_MASK: cfg_next.escape_mask = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_code  <= RST_START_CODE;
            cfg_reg.escape_code <= RST_ESCAPE_CODE;
            cfg_reg.escape_mask <= RST_ESCAPE_MASK;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tfs_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    tfs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    tfs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### tb/telemetry_frame_serializer_core_tb.sv
`timescale 1ns / 1ps

module telemetry_frame_serializer_core_tb;
    import tfs_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 13;
    localparam int PLAN_ROWS    = 17;

    // no register behind this index; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    // idle profiles: none, sender idle, receiver stalling, both
    localparam int IDLE_SEND [4] = '{0, 61, 0, 8};
    localparam int IDLE_RECV [4] = '{0, 0, 61, 8};

    typedef struct packed {
        bit          set_codes;
        logic [7:0]  start_code;
        logic [7:0]  escape_code;
        logic [7:0]  escape_mask;
        logic [15:0] sensor_id;
        logic [31:0] data_value;
        logic        empty_frame;
        bit          typed;
        logic [63:0] line;      // first line byte in the top bits
    } plan_row_t;

    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // reset codes, no stuffing: line bytes typed in
        '{1'b0, 8'h00, 8'h00, 8'h00, 16'h0000, 32'h0000_0000, 1'b1,
          1'b1, 64'h00_00_00_00_00_00_00_FF},
        '{1'b0, 8'h00, 8'h00, 8'h00, 16'h0000, 32'h0000_0000, 1'b0,
          1'b1, 64'h10_00_00_00_00_00_00_EF},
        '{1'b0, 8'h00, 8'h00, 8'h00, 16'hFFFF, 32'hFFFF_FFFF, 1'b0,
          1'b1, 64'h10_FF_FF_FF_FF_FF_FF_EF},
        // empty frame ignores the payload
        '{1'b0, 8'h00, 8'h00, 8'h00, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
          1'b1, 64'h00_FF_FF_00_00_00_00_00},
        '{1'b0, 8'h00, 8'h00, 8'h00, 16'h7E7D, 32'h7D7E_5E5D, 1'b0, 1'b0, 64'h0},
        // check byte lands on the start code, then on the escape code
        '{1'b0, 8'h00, 8'h00, 8'h00, 16'h0081, 32'h0000_0000, 1'b1, 1'b0, 64'h0},
        '{1'b0, 8'h00, 8'h00, 8'h00, 16'h0082, 32'h0000_0000, 1'b1, 1'b0, 64'h0},
        '{1'b0, 8'h00, 8'h00, 8'h00, 16'h5E5D, 32'h7D7D_7E7E, 1'b0, 1'b0, 64'h0},
        // every byte escaped, type and check included: longest frame
        '{1'b1, 8'h10, 8'h8F, 8'hFF, 16'h1010, 32'h1010_1010, 1'b0, 1'b0, 64'h0},
        // start equal to escape, zero mask
        '{1'b1, 8'h55, 8'h55, 8'h00, 16'h5555, 32'h0055_0055, 1'b0, 1'b0, 64'h0},
        '{1'b0, 8'h00, 8'h00, 8'h00, 16'h55AA, 32'h5555_5555, 1'b1, 1'b0, 64'h0},
        // extreme codes
        '{1'b1, 8'h00, 8'hFF, 8'hFF, 16'h00FF, 32'hFF00_00FF, 1'b0, 1'b0, 64'h0},
        '{1'b0, 8'h00, 8'h00, 8'h00, 16'h0000, 32'h0000_0000, 1'b1, 1'b0, 64'h0},
        '{1'b1, 8'hFF, 8'h00, 8'h00, 16'hFF00, 32'h00FF_00FF, 1'b0, 1'b0, 64'h0},
        '{1'b1, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 32'h0000_0000, 1'b0, 1'b0, 64'h0},
        '{1'b1, 8'h00, 8'h00, 8'h80, 16'h8000, 32'h1234_5678, 1'b1, 1'b0, 64'h0},
        '{1'b1, 8'h7E, 8'h7D, 8'h20, 16'h1234, 32'hDEAD_BEEF, 1'b0, 1'b0, 64'h0}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_data;

    logic [7:0] cur_start;
    logic [7:0] cur_escape;
    logic [7:0] cur_mask;
    out_item_t  line_exp [$];
    int         errors;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         quiet;

    telemetry_frame_serializer_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // builds the frame, folds the sum, stuffs it and queues the line bytes
    function automatic void predict_frame(input in_item_t rpt);
        logic [7:0]  fb [FRAME_LEN];
        logic [31:0] val;
        logic [7:0]  b;
        int unsigned acc;
        val   = rpt.empty_frame ? 32'd0 : rpt.data_value;
        fb[0] = rpt.empty_frame ? TYPE_EMPTY : TYPE_DATA;
        fb[1] = rpt.sensor_id[7:0];
        fb[2] = rpt.sensor_id[15:8];
        fb[3] = val[7:0];
        fb[4] = val[15:8];
        fb[5] = val[23:16];
        fb[6] = val[31:24];
        acc = 0;
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            acc += fb[i];
            acc = (acc + (acc >> 8)) & 32'hFF;
            acc = (acc + (acc >> 8)) & 32'hFF;
        end
        fb[FRAME_LEN-1] = CHECK_BASE - 8'(acc);
        for (int i = 0; i < FRAME_LEN; i++) begin
            b = fb[i];
            if (b == cur_start || b == cur_escape) begin
                line_exp.push_back('{line_byte: cur_escape, frame_end: 1'b0});
                b = b & ~cur_mask;
            end
            line_exp.push_back('{line_byte: b, frame_end: (i == FRAME_LEN - 1)});
        end
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(5))
            0: return cur_start;
            1: return cur_escape;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        case (idx)
            REG_START_CODE:  cur_start  = val;
            REG_ESCAPE_CODE: cur_escape = val;
            REG_ESCAPE_MASK: cur_mask   = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // codes change only once the line has drained
    task automatic load_codes(input logic [7:0] sc, input logic [7:0] ec,
                              input logic [7:0] em);
        s_valid <= 1'b0;
        while (line_exp.size() != 0) @(negedge aclk);
        write_reg(REG_UNMAPPED, 8'($urandom));
        write_reg(REG_START_CODE, sc);
        write_reg(REG_ESCAPE_CODE, ec);
        write_reg(REG_ESCAPE_MASK, em);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_report(input in_item_t rpt, input bit typed,
                               input logic [63:0] line);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= rpt;
        do @(posedge aclk); while (!(s_valid && s_ready));
        if (typed) begin
            for (int k = 0; k < FRAME_LEN; k++)
                line_exp.push_back('{line_byte: line[63 - 8 * k -: 8],
                                     frame_end: (k == FRAME_LEN - 1)});
        end else begin
            predict_frame(rpt);
        end
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : line_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (line_exp.size() == 0) begin
                $error("line_byte: expected none, got %02h", m_data.line_byte);
                errors++;
            end else begin
                want = line_exp.pop_front();
                if (m_data.line_byte !== want.line_byte) begin
                    $error("line_byte: expected %02h, got %02h",
                           want.line_byte, m_data.line_byte);
                    errors++;
                end
                if (m_data.frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0b, got %0b",
                           want.frame_end, m_data.frame_end);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("telemetry_frame_serializer_core_tb: FAIL");
            $finish;
        end
    end

    initial begin : run
        in_item_t   rpt;
        logic [7:0] sc;
        logic [7:0] ec;
        logic [7:0] em;
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        errors         = 0;
        quiet          = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cur_start      = RST_START_CODE;
        cur_escape     = RST_ESCAPE_CODE;
        cur_mask       = RST_ESCAPE_MASK;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (PLAN[r].set_codes)
                load_codes(PLAN[r].start_code, PLAN[r].escape_code, PLAN[r].escape_mask);
            rpt.sensor_id   = PLAN[r].sensor_id;
            rpt.data_value  = PLAN[r].data_value;
            rpt.empty_frame = PLAN[r].empty_frame;
            send_report(rpt, PLAN[r].typed, PLAN[r].line);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            case ($urandom_range(3))
                0: begin
                    sc = RST_START_CODE;
                    ec = RST_ESCAPE_CODE;
                    em = RST_ESCAPE_MASK;
                end
                1: begin
                    sc = 8'($urandom);
                    ec = 8'($urandom);
                    em = 8'($urandom);
                end
                2: begin
                    sc = 8'($urandom);
                    ec = sc;
                    em = 8'($urandom);
                end
                default: begin
                    sc = $urandom_range(1) ? 8'hFF : 8'h00;
                    ec = $urandom_range(1) ? ~sc : 8'($urandom);
                    em = $urandom_range(1) ? 8'hFF : 8'h00;
                end
            endcase
            load_codes(sc, ec, em);
            send_idle_pct  = IDLE_SEND[p % 4];
            recv_stall_pct = IDLE_RECV[p % 4];
            repeat (PHASE_ITEMS) begin
                rpt.sensor_id   = {pick_byte(), pick_byte()};
                rpt.data_value  = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
                rpt.empty_frame = ($urandom_range(3) == 0);
                send_report(rpt, 1'b0, 64'h0);
            end
        end

        s_valid <= 1'b0;
        while (line_exp.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (errors == 0)
            $display("telemetry_frame_serializer_core_tb: PASS");
        else
            $display("telemetry_frame_serializer_core_tb: FAIL");
        $finish;
    end

endmodule

### files.f
design/tfs_pkg.sv
design/tfs_front.sv
design/tfs_queue.sv
design/tfs_back.sv
design/telemetry_frame_serializer_core.sv
tb/telemetry_frame_serializer_core_tb.sv
